// File: rtl/core/fxd_pkg.sv
// Shared types and constants for the framed packet XOR deframer.
// Used by fxd_frame_track, fxd_result_buf and framed_packet_xor_deframer.
`default_nettype none

package fxd_pkg;

  // Frame layout: start, command, length, payload, checksum, end.
  localparam logic [7:0] START_MARK     = 8'hAA;
  localparam logic [7:0] END_MARK       = 8'h55;
  localparam int         FRAME_OVERHEAD = 5;
  localparam int         MAX_PAYLOAD    = 64;

  localparam int         CNT_W          = 9;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam int         IDX_W          = 6;
  localparam int         ERR_W          = 3;

  // Packed result word width, padded up to whole bytes.
  localparam int         RES_BITS       = 8 + IDX_W + 8 + 8 + 1 + ERR_W;
  localparam int         OUT_TDATA_W    = ((RES_BITS + 7) / 8) * 8;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK       = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_MARKER   = 3'd2,
    ERR_LENGTH   = 3'd3,
    ERR_CHECKSUM = 3'd4
  } err_code_t;

  typedef struct packed {
    logic             is_final;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] payload_index;
    logic [7:0]       command;
    logic [7:0]       data_length;
    logic             frame_ok;
    err_code_t        error_code;
  } fxd_result_t;

endpackage

`default_nettype wire

// File: rtl/core/framed_packet_xor_deframer.sv
// Top level of the framed packet XOR deframer.
// Depends on fxd_pkg, fxd_frame_track and fxd_result_buf.
//
// The input stream carries one frame byte per transfer in in_tdata, with
// in_tlast set on the frame's final byte. A frame is 0xAA, command, length,
// payload, XOR checksum, 0x55. Each payload byte inside the declared length
// (and below the maximum payload size) of a frame with a good start byte
// yields one result transfer with out_tuser low; the final byte yields one
// verdict transfer with out_tuser high, carrying frame_ok and an error code.
// Other bytes yield no result. Frame state is updated in the same cycle a
// byte is accepted; a result goes into the output register or skid entry.
// Throughput is one byte per cycle: the count and XOR update is a single
// short step, and a two-entry result buffer (output register plus skid
// entry) keeps in_tready high while one result waits. in_tready drops only
// when both entries hold results the receiver has not yet taken.
// Reset (rst_n low, synchronous) clears the frame state and empties the
// result buffer; the next byte is treated as a frame's first byte.
// After every final byte the frame state clears for the next frame.
`default_nettype none

module framed_packet_xor_deframer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,  // [7:0] data_byte
  input  wire logic                             in_tlast,  // last_byte
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [7:0] payload_byte, [13:8] payload_index, [21:14] command,
  // [29:22] data_length, [30] frame_ok, [33:31] error_code, rest zero
  output logic [fxd_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tuser   // is_final
);
  import fxd_pkg::*;

  logic        in_xfer;
  logic        res_valid;
  fxd_result_t res;
  fxd_result_t head;
  logic        can_push;

  // A byte is taken whenever the buffer has a free entry.
  assign in_tready = can_push;
  assign in_xfer   = in_tvalid && in_tready;

  fxd_frame_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_xfer),
    .data_byte  (in_tdata),
    .last_byte  (in_tlast),
    .res        (res),
    .res_valid  (res_valid)
  );

  fxd_result_buf u_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .can_push   (can_push),
    .head_valid (out_tvalid),
    .head_data  (head),
    .pop        (out_tvalid && out_tready)
  );

  // Pack the result fields, lowest field first, padded with zeros.
  assign out_tuser = head.is_final;
  assign out_tdata = {{(OUT_TDATA_W-RES_BITS){1'b0}},
                      head.error_code,
                      head.frame_ok,
                      head.data_length,
                      head.command,
                      head.payload_index,
                      head.payload_byte};

endmodule

`default_nettype wire

// File: rtl/core/fxd_frame_track.sv
// Per-frame state (count, running XOR, command, length, start check) and the
// combinational result logic. Depends on fxd_pkg.
`default_nettype none

module fxd_frame_track (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               byte_valid,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last_byte,
  output fxd_pkg::fxd_result_t    res,
  output logic                    res_valid
);
  import fxd_pkg::*;

  localparam logic [CNT_W-1:0] MAX_PAY_C  = CNT_W'(MAX_PAYLOAD);
  localparam logic [CNT_W-1:0] OVERHEAD_C = CNT_W'(FRAME_OVERHEAD);

  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]       running_xor_r, running_xor_nxt;
  logic [7:0]       command_byte_r, command_byte_nxt;
  logic [7:0]       length_byte_r, length_byte_nxt;
  logic             start_ok_r, start_ok_nxt;

  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] len_ext;
  logic [CNT_W-1:0] idx;
  err_code_t        err;

  always_comb begin
    len_ext = {{(CNT_W-8){1'b0}}, length_byte_r};
    total   = (byte_count_r == COUNT_MAX) ? COUNT_MAX : byte_count_r + 1'b1;
    idx     = byte_count_r - CNT_W'(3);

    if (total < OVERHEAD_C) begin
      err = ERR_SHORT;
    end else if (!start_ok_r || data_byte != END_MARK) begin
      err = ERR_MARKER;
    end else if (len_ext > MAX_PAY_C || total != OVERHEAD_C + len_ext) begin
      err = ERR_LENGTH;
    end else if (running_xor_r != 8'h00) begin
      err = ERR_CHECKSUM;
    end else begin
      err = ERR_OK;
    end
  end

  always_comb begin
    byte_count_nxt   = byte_count_r;
    running_xor_nxt  = running_xor_r;
    command_byte_nxt = command_byte_r;
    length_byte_nxt  = length_byte_r;
    start_ok_nxt     = start_ok_r;
    res              = '0;
    res.command      = command_byte_r;
    res.data_length  = length_byte_r;
    res.error_code   = ERR_OK;
    res_valid        = 1'b0;

    if (byte_valid) begin
      if (last_byte) begin
        res.is_final     = 1'b1;
        res.frame_ok     = (err == ERR_OK);
        res.error_code   = err;
        res_valid        = 1'b1;
        byte_count_nxt   = '0;
        running_xor_nxt  = '0;
        command_byte_nxt = '0;
        length_byte_nxt  = '0;
        start_ok_nxt     = 1'b0;
      end else begin
        if (byte_count_r == '0) begin
          start_ok_nxt = (data_byte == START_MARK);
        end else begin
          running_xor_nxt = running_xor_r ^ data_byte;
          if (byte_count_r == CNT_W'(1)) begin
            command_byte_nxt = data_byte;
          end else if (byte_count_r == CNT_W'(2)) begin
            length_byte_nxt = data_byte;
          end else if (start_ok_r && idx < len_ext && idx < MAX_PAY_C) begin
            // Payload byte within the declared length.
            res.payload_byte  = data_byte;
            res.payload_index = idx[IDX_W-1:0];
            res_valid         = 1'b1;
          end
        end
        if (byte_count_r != COUNT_MAX) begin
          byte_count_nxt = byte_count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= '0;
      running_xor_r  <= '0;
      command_byte_r <= '0;
      length_byte_r  <= '0;
      start_ok_r     <= 1'b0;
    end else begin
      byte_count_r   <= byte_count_nxt;
      running_xor_r  <= running_xor_nxt;
      command_byte_r <= command_byte_nxt;
      length_byte_r  <= length_byte_nxt;
      start_ok_r     <= start_ok_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fxd_result_buf.sv
// Two-entry result buffer: an output register plus a skid entry, so input
// stays open while the receiver stalls, until both entries are full. Depends on fxd_pkg.
`default_nettype none

module fxd_result_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  fxd_pkg::fxd_result_t   push_data,
  output logic                   can_push,
  output logic                   head_valid,
  output fxd_pkg::fxd_result_t   head_data,
  input  wire logic              pop
);
  import fxd_pkg::*;

  logic [1:0]  count_r, count_nxt;
  fxd_result_t head_r, head_nxt;
  fxd_result_t skid_r, skid_nxt;

  assign can_push   = (count_r != 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_data  = head_r;

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    skid_nxt  = skid_r;
    case (count_r)
      2'd0: begin
        if (push) begin
          head_nxt  = push_data;
          count_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_data;
        end else if (push) begin
          skid_nxt  = push_data;
          count_nxt = 2'd2;
        end else if (pop) begin
          count_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt  = skid_r;
          count_nxt = 2'd1;
        end
      end
      default: begin
        count_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

// File: sim/fxd_frame_checker.sv
`timescale 1ns / 1ps
// Result checker for the framed packet XOR deframer testbench.
// Tracks frame state from accepted input transfers, predicts each result and
// compares it with the output transfers. Depends on fxd_pkg.

module fxd_frame_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  input  wire logic                       in_tready,
  input  wire logic [7:0]                 in_tdata,
  input  wire logic                       in_tlast,
  input  wire logic                       out_tvalid,
  input  wire logic                       out_tready,
  input  wire logic [fxd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                       out_tuser,
  output int                              mismatches,
  output int                              open_results
);
  import fxd_pkg::*;

  logic [CNT_W-1:0] frame_count;
  logic [7:0]       frame_xor;
  logic [7:0]       frame_cmd;
  logic [7:0]       frame_len;
  logic             start_ok;

  fxd_result_t expected_results[$];

  function automatic void clear_frame();
    frame_count = '0;
    frame_xor   = '0;
    frame_cmd   = '0;
    frame_len   = '0;
    start_ok    = 1'b0;
  endfunction

  // Advances the frame state by one byte; returns 1 when the byte yields a result.
  function automatic bit advance_frame(input logic [7:0] b, input logic at_end,
                                       output fxd_result_t res);
    logic [CNT_W:0]   total;
    logic [CNT_W-1:0] idx;
    err_code_t        err;
    res = '0;
    if (at_end) begin
      total = {1'b0, frame_count} + 1'b1;
      if (total > COUNT_MAX) total = {1'b0, COUNT_MAX};
      if (total < FRAME_OVERHEAD) err = ERR_SHORT;
      else if (!start_ok || b != END_MARK) err = ERR_MARKER;
      else if (frame_len > MAX_PAYLOAD || total != FRAME_OVERHEAD + frame_len) err = ERR_LENGTH;
      else if (frame_xor != 8'h00) err = ERR_CHECKSUM;
      else err = ERR_OK;
      res.is_final    = 1'b1;
      res.command     = frame_cmd;
      res.data_length = frame_len;
      res.frame_ok    = (err == ERR_OK);
      res.error_code  = err;
      clear_frame();
      return 1'b1;
    end
    advance_frame = 1'b0;
    if (frame_count == 0) begin
      start_ok = (b == START_MARK);
    end else begin
      frame_xor = frame_xor ^ b;
      if (frame_count == 1) frame_cmd = b;
      else if (frame_count == 2) frame_len = b;
      else begin
        idx = frame_count - CNT_W'(3);
        if (start_ok && idx < frame_len && idx < MAX_PAYLOAD) begin
          res.payload_byte  = b;
          res.payload_index = idx[IDX_W-1:0];
          res.command       = frame_cmd;
          res.data_length   = frame_len;
          advance_frame     = 1'b1;
        end
      end
    end
    if (frame_count != COUNT_MAX) frame_count = frame_count + 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s mismatch: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    fxd_result_t res;
    fxd_result_t want;
    if (!rst_n) begin
      clear_frame();
      expected_results.delete();
    end else begin
      // Expectations go in first so a result is always matched against older bytes.
      if (in_tvalid && in_tready) begin
        if (advance_frame(in_tdata, in_tlast, res)) expected_results.push_back(res);
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result tdata", 64'(out_tdata), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.is_final)
            report_mismatch("is_final", 64'(out_tuser), 64'(want.is_final));
          if (out_tdata[7:0] !== want.payload_byte)
            report_mismatch("payload_byte", 64'(out_tdata[7:0]), 64'(want.payload_byte));
          if (out_tdata[13:8] !== want.payload_index)
            report_mismatch("payload_index", 64'(out_tdata[13:8]),
                            64'(want.payload_index));
          if (out_tdata[21:14] !== want.command)
            report_mismatch("command", 64'(out_tdata[21:14]), 64'(want.command));
          if (out_tdata[29:22] !== want.data_length)
            report_mismatch("data_length", 64'(out_tdata[29:22]), 64'(want.data_length));
          if (out_tdata[30] !== want.frame_ok)
            report_mismatch("frame_ok", 64'(out_tdata[30]), 64'(want.frame_ok));
          if (out_tdata[33:31] !== want.error_code)
            report_mismatch("error_code", 64'(out_tdata[33:31]), 64'(want.error_code));
          if (out_tdata[fxd_pkg::OUT_TDATA_W-1:34] !== '0)
            report_mismatch("tdata padding", 64'(out_tdata[fxd_pkg::OUT_TDATA_W-1:34]), '0);
        end
      end
    end
    open_results <= expected_results.size();
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Top of the framed packet XOR deframer testbench: clock, reset, stimulus and verdict.
// Depends on fxd_pkg, framed_packet_xor_deframer and fxd_frame_checker.

module testbench;
  import fxd_pkg::*;

  // A run of this many cycles with no transfer on either channel means the block hung.
  localparam int STALL_LIMIT = 4000;

  logic clk;
  logic rst_n      = 1'b0;
  logic in_tvalid  = 1'b0;
  logic [7:0] in_tdata = 8'h00;
  logic in_tlast   = 1'b0;
  logic out_tready = 1'b0;
  logic in_tready;
  logic out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;

  int mismatches;
  int open_results;
  int bytes_sent  = 0;
  int idle_cycles = 0;

  // When set, neither side inserts gaps, so whole frames go through back to back.
  bit quiet = 1'b0;

  // Bytes of the frame being built; the last one goes out with in_tlast high.
  logic [7:0] frame_q[$];

  framed_packet_xor_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  fxd_frame_checker frame_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .mismatches   (mismatches),
    .open_results (open_results)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic void open_frame(input logic [7:0] start_b, input logic [7:0] cmd_b,
                                     input logic [7:0] len_b);
    frame_q.delete();
    frame_q.push_back(start_b);
    frame_q.push_back(cmd_b);
    frame_q.push_back(len_b);
  endfunction

  function automatic void add_payload(input int count);
    repeat (count) frame_q.push_back(rand_byte());
  endfunction

  // Appends the checksum (XOR of everything after the start byte, optionally
  // corrupted by cs_flip) and the end byte.
  function automatic void close_frame(input logic [7:0] cs_flip, input logic [7:0] end_b);
    logic [7:0] x;
    int i;
    x = 8'h00;
    for (i = 1; i < frame_q.size(); i++) x = x ^ frame_q[i];
    frame_q.push_back(x ^ cs_flip);
    frame_q.push_back(end_b);
  endfunction

  // Offers one byte after a random gap and returns at the edge where the
  // transfer takes place. in_tvalid stays high into the next call when no gap follows.
  task automatic send_byte(input logic [7:0] value, input logic final_flag);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= final_flag;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Holds the input idle until the checker has seen every expected result.
  // The first edge lets the checker account for the byte just transferred.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
  endtask

  // Receiver side: ready in bursts, stalls of random length in between.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Watchdog on forward progress of either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int kind;
    int plen;
    int count;
    logic [7:0] b;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames. A lone start byte flagged as final is too short.
    frame_q.delete();
    frame_q.push_back(START_MARK);
    send_frame();

    // Good frame with payload bytes at both extremes and the largest command.
    open_frame(START_MARK, 8'hFF, 8'h02);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    close_frame(8'h00, END_MARK);
    send_frame();

    // Bad start byte: the payload must not be emitted, verdict is a marker error.
    open_frame(8'h00, 8'h5A, 8'h01);
    add_payload(1);
    close_frame(8'h00, END_MARK);
    send_frame();

    // Bad end byte on an otherwise correct empty frame.
    open_frame(START_MARK, 8'h00, 8'h00);
    close_frame(8'h00, 8'hFF);
    send_frame();

    // Checksum mismatch with the top bit flipped.
    open_frame(START_MARK, 8'h3C, 8'h00);
    close_frame(8'h80, END_MARK);
    send_frame();

    // Final byte arrives while the declared payload is still running.
    open_frame(START_MARK, 8'h02, 8'h04);
    frame_q.push_back(8'h11);
    frame_q.push_back(8'h22);
    frame_q.push_back(END_MARK);
    send_frame();

    // Declared length just above the payload limit.
    open_frame(START_MARK, 8'h03, 8'(MAX_PAYLOAD + 1));
    close_frame(8'h00, END_MARK);
    send_frame();

    // Let everything drain before the random part begins.
    wait_for_drain();

    // Random frames: mostly well formed with random content, the rest broken
    // in one way each, plus some raw noise.
    while (bytes_sent < 450) begin
      quiet = ($urandom_range(0, 9) == 0);
      kind  = $urandom_range(0, 99);
      if (kind < 55) begin
        plen = ($urandom_range(0, 19) == 0) ? MAX_PAYLOAD : $urandom_range(0, 8);
        open_frame(START_MARK, rand_byte(), 8'(plen));
        add_payload(plen);
        close_frame(8'h00, END_MARK);
      end else if (kind < 60) begin
        b = rand_byte();
        if (b == START_MARK) b = 8'h00;
        plen = $urandom_range(0, 4);
        open_frame(b, rand_byte(), 8'(plen));
        add_payload(plen);
        close_frame(8'h00, END_MARK);
      end else if (kind < 65) begin
        b = rand_byte();
        if (b == END_MARK) b = 8'hFF;
        plen = $urandom_range(0, 4);
        open_frame(START_MARK, rand_byte(), 8'(plen));
        add_payload(plen);
        close_frame(8'h00, b);
      end else if (kind < 72) begin
        plen = $urandom_range(0, 6);
        open_frame(START_MARK, rand_byte(), 8'(plen));
        add_payload(plen);
        close_frame(8'($urandom_range(1, 255)), END_MARK);
      end else if (kind < 79) begin
        // Payload count disagrees with the declared length.
        plen  = $urandom_range(1, 8);
        count = $urandom_range(0, 1) ? plen + $urandom_range(1, 3) : $urandom_range(0, plen - 1);
        open_frame(START_MARK, rand_byte(), 8'(plen));
        add_payload(count);
        close_frame(8'h00, END_MARK);
      end else if (kind < 84) begin
        // Declared length above the limit; sometimes enough bytes to pass the
        // point where payload emission must stop.
        plen  = $urandom_range(MAX_PAYLOAD + 1, 255);
        count = ($urandom_range(0, 9) == 0) ? MAX_PAYLOAD + 6 : $urandom_range(0, 4);
        open_frame(START_MARK, rand_byte(), 8'(plen));
        add_payload(count);
        close_frame(8'h00, END_MARK);
      end else if (kind < 90) begin
        // Truncated frame, shorter than the fixed overhead.
        frame_q.delete();
        frame_q.push_back($urandom_range(0, 1) ? START_MARK : rand_byte());
        repeat ($urandom_range(0, 3)) frame_q.push_back(rand_byte());
      end else begin
        frame_q.delete();
        repeat ($urandom_range(1, 12)) frame_q.push_back(rand_byte());
      end
      send_frame();
      if ($urandom_range(0, 24) == 0) wait_for_drain();
    end
    quiet = 1'b0;

    wait_for_drain();
    repeat (10) @(posedge clk);

    if (mismatches == 0 && open_results == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/fxd_pkg.sv
rtl/core/fxd_frame_track.sv
rtl/core/fxd_result_buf.sv
rtl/core/framed_packet_xor_deframer.sv
sim/fxd_frame_checker.sv
sim/testbench.sv
